@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define QPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle, checked outside reset.
`define QPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qpd_pkg.sv @@
package qpd_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAG_W       = SAMPLE_W;
  localparam int unsigned SQ_W        = 2 * MAG_W;
  localparam int unsigned MAX_WINDOW  = 64;
  localparam int unsigned WIN_AW      = $clog2(MAX_WINDOW);
  localparam int unsigned FILL_W      = WIN_AW + 1;
  localparam int unsigned SUM_W       = 38;
  localparam int unsigned LEVEL_W     = 46;
  localparam int unsigned IDX_W       = 32;

  // A window sum enters a level scaled by 32 (5 fraction bits, one-eighth step).
  localparam int unsigned LEVEL_SHIFT = 5;
  // Threshold comparison: value scaled by 2^16 against noise*2^8 + factor*(signal-noise).
  localparam int unsigned THR_SHIFT   = 8;
  localparam int unsigned VAL_SHIFT   = 16;

  localparam int unsigned WLEN_W      = 7;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned FACTOR_W    = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned PROD_W      = (LEVEL_W + 1) + (FACTOR_W + 1);
  localparam int unsigned CMP_W       = PROD_W + 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QUEUE_AW + 1;

  localparam logic [WLEN_W-1:0]   RST_WINDOW_LEN = WLEN_W'(30);
  localparam logic [LEN_W-1:0]    RST_REFRACTORY = LEN_W'(72);
  localparam logic [LEN_W-1:0]    RST_SKIP_LEN   = LEN_W'(100);
  localparam logic [LEN_W-1:0]    RST_LEARN_LEN  = LEN_W'(500);
  localparam logic [FACTOR_W-1:0] RST_FACTOR     = FACTOR_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN     = 3'd0,
    REG_REFRACTORY_LEN = 3'd1,
    REG_SKIP_LEN       = 3'd2,
    REG_LEARN_LEN      = 3'd3,
    REG_THRESH_FACTOR  = 3'd4
  } cfg_reg_e;

  typedef enum logic [0:0] {
    JOB_SEED = 1'b0,
    JOB_TEST = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [IDX_W-1:0]   index;
    logic [SUM_W-1:0]   value;
  } job_t;

  typedef struct packed {
    logic [WLEN_W-1:0]   window_len;
    logic [LEN_W-1:0]    refractory_len;
    logic [LEN_W-1:0]    skip_len;
    logic [LEN_W-1:0]    learn_len;
    logic [FACTOR_W-1:0] thr_weight;
  } cfg_t;

  function automatic logic [LEVEL_W-1:0] seed_level(input logic [SUM_W-1:0] val);
    seed_level = LEVEL_W'(val) << LEVEL_SHIFT;
  endfunction

  function automatic logic [LEVEL_W-1:0] step_level(input logic [LEVEL_W-1:0] lvl,
                                                    input logic [SUM_W-1:0]   val);
    step_level = lvl - (lvl >> 3) + (LEVEL_W'(val) << LEVEL_SHIFT);
  endfunction

endpackage

@@ rtl/qrs_peak_detector.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   sample_i (16 bit signed)
// result    out        out_valid_o / out_stall_i peak_index_o (32), peak_height_o (38)
// config    in         cfg_we_i                  cfg_idx_i (3), cfg_wdata_i (16)
//
// One sample transaction is taken every cycle while the job queue has room.
// A peak is raised once the sample after it has passed the front pipeline, the
// job queue and the level tracker, which pops the queue. A local maximum takes
// the tracker through its idle and test states, and maxima lie at least two
// samples apart, so it keeps pace with one sample a cycle. Reset clears control
// state and restores the register defaults; the window memory needs no clearing.
// A stalled result holds the tracker, and the input stalls once the queue is full.
module qrs_peak_detector import qpd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [IDX_W-1:0]           peak_index_o,
  output logic [SUM_W-1:0]           peak_height_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i
);

  // Configuration registers. Writes must arrive only while the block is idle, which
  // the block does not enforce; they are taken directly with no shadowing.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len     <= RST_WINDOW_LEN;
      cfg_q.refractory_len <= RST_REFRACTORY;
      cfg_q.skip_len       <= RST_SKIP_LEN;
      cfg_q.learn_len      <= RST_LEARN_LEN;
      cfg_q.thr_weight     <= RST_FACTOR;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_LEN:     cfg_q.window_len     <= cfg_wdata_i[WLEN_W-1:0];
        REG_REFRACTORY_LEN: cfg_q.refractory_len <= cfg_wdata_i[LEN_W-1:0];
        REG_SKIP_LEN:       cfg_q.skip_len       <= cfg_wdata_i[LEN_W-1:0];
        REG_LEARN_LEN:      cfg_q.learn_len      <= cfg_wdata_i[LEN_W-1:0];
        REG_THRESH_FACTOR:  cfg_q.thr_weight     <= cfg_wdata_i[FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: differencing, squaring, the moving window sum and the decision
  // of which averaged values seed the levels or need a threshold test.
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  qpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // The queue lets the classifier run on while a result waits downstream.
  qpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: signal and noise levels, refractory check and the result register.
  qpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_i         (head_job),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .peak_index_o  (peak_index_o),
    .peak_height_o (peak_height_o)
  );

endmodule

@@ rtl/qpd_front.sv @@
`include "assert_macros.svh"

// Sample conditioning and peak classification. A five-stage pipeline that
// advances as a whole whenever the job queue has room.
module qpd_front import qpd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output job_t                       job_o
);

  logic en;
  logic accept;

  assign en         = !q_full_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && en;

  // Stage 0: difference magnitude against the previous sample.
  logic                have_prev_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [SAMPLE_W:0]   diff;
  logic [MAG_W-1:0]    mag;

  assign diff = {sample_i[SAMPLE_W-1], sample_i} - {prev_q[SAMPLE_W-1], prev_q};
  assign mag  = diff[SAMPLE_W] ? MAG_W'(~diff + 1'b1) : MAG_W'(diff);

  logic             p1_valid_q;
  logic [MAG_W-1:0] p1_mag_q;

  // Stage 1: square.
  logic            p2_valid_q;
  logic [SQ_W-1:0] p2_sq_q;

  // Stage 2: running total of squares and window base lookup.
  logic [SUM_W-1:0]  cum_q;
  logic [SUM_W-1:0]  cum_d;
  logic [WIN_AW-1:0] wr_ptr_q;
  logic [WIN_AW-1:0] rd_addr;
  logic [FILL_W-1:0] fill_q;
  logic [WLEN_W-1:0] wl;
  logic [WLEN_W-1:0] wl_m1;
  logic [SUM_W-1:0]  cum_mem [MAX_WINDOW];

  always_comb begin
    if (cfg_i.window_len == '0) begin
      wl = WLEN_W'(1);
    end else if (cfg_i.window_len > WLEN_W'(MAX_WINDOW)) begin
      wl = WLEN_W'(MAX_WINDOW);
    end else begin
      wl = cfg_i.window_len;
    end
  end

  assign wl_m1   = wl - WLEN_W'(1);
  assign cum_d   = cum_q + SUM_W'(p2_sq_q);
  assign rd_addr = wr_ptr_q - wl[WIN_AW-1:0];

  logic             p3_valid_q;
  logic [SUM_W-1:0] p3_cum_q;
  logic             p3_base_zero_q;
  logic             p3_filled_q;
  logic [SUM_W-1:0] rdata_q;

  // Stage 3: window sum.
  logic [SUM_W-1:0] val3;

  assign val3 = !p3_filled_q    ? '0 :
                p3_base_zero_q  ? p3_cum_q :
                                  p3_cum_q - rdata_q;

  logic             p4_valid_q;
  logic [SUM_W-1:0] p4_val_q;

  // Stage 4: learning, seeding and local maximum test.
  logic [IDX_W-1:0] avg_count_q;
  logic [SUM_W-1:0] before_q;
  logic [SUM_W-1:0] middle_q;
  logic [SUM_W-1:0] lmax_q;
  logic             seeded_q;

  logic [LEN_W-1:0] learn_eff;
  logic [LEN_W:0]   seed_at;
  logic             in_learn;
  logic             seed_now;
  logic             is_test;
  logic [SUM_W-1:0] lmax_next;
  logic             s4_go;

  assign learn_eff = (cfg_i.learn_len == '0) ? LEN_W'(1) : cfg_i.learn_len;
  assign seed_at   = {1'b0, cfg_i.skip_len} + {1'b0, learn_eff} - (LEN_W + 1)'(1);
  assign in_learn  = !seeded_q && (avg_count_q >= IDX_W'(cfg_i.skip_len));
  assign lmax_next = (p4_val_q > lmax_q) ? p4_val_q : lmax_q;
  assign seed_now  = in_learn && (avg_count_q >= IDX_W'(seed_at));
  assign is_test   = seeded_q && (middle_q > before_q) && (middle_q > p4_val_q);
  assign s4_go     = en && p4_valid_q;

  assign push_o = s4_go && (seed_now || is_test);

  always_comb begin
    if (seed_now) begin
      job_o.kind  = JOB_SEED;
      job_o.index = '0;
      job_o.value = lmax_next;
    end else begin
      job_o.kind  = JOB_TEST;
      job_o.index = avg_count_q - IDX_W'(1);
      job_o.value = middle_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p4_valid_q  <= 1'b0;
      cum_q       <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      avg_count_q <= '0;
      before_q    <= '0;
      middle_q    <= '0;
      lmax_q      <= '0;
      seeded_q    <= 1'b0;
    end else if (en) begin
      if (in_valid_i) begin
        have_prev_q <= 1'b1;
      end
      p1_valid_q <= accept && have_prev_q;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
      if (p2_valid_q) begin
        cum_q    <= cum_d;
        wr_ptr_q <= wr_ptr_q + WIN_AW'(1);
        if (fill_q != FILL_W'(MAX_WINDOW)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (p4_valid_q) begin
        if (in_learn) begin
          lmax_q <= lmax_next;
        end
        if (seed_now) begin
          seeded_q <= 1'b1;
        end
        before_q    <= middle_q;
        middle_q    <= p4_val_q;
        avg_count_q <= avg_count_q + IDX_W'(1);
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q <= sample_i;
    end
    if (en) begin
      p1_mag_q       <= mag;
      p2_sq_q        <= SQ_W'(p1_mag_q * p1_mag_q);
      p3_cum_q       <= cum_d;
      p3_base_zero_q <= (fill_q == FILL_W'(wl_m1));
      p3_filled_q    <= (fill_q >= FILL_W'(wl_m1));
      p4_val_q       <= val3;
    end
  end

  // Running totals of the last MAX_WINDOW squares; read before write.
  always_ff @(posedge clk_i) begin
    if (en && p2_valid_q) begin
      cum_mem[wr_ptr_q] <= cum_d;
      rdata_q           <= cum_mem[rd_addr];
    end
  end

  `QPD_ASSERT_NEXT(a_seed_once, clk_i, rst_ni, seeded_q, seeded_q, "levels seeded twice")

endmodule

@@ rtl/qpd_queue.sv @@
`include "assert_macros.svh"

// Short job queue between the classifier and the level tracker.
module qpd_queue import qpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q;
  logic [QUEUE_AW-1:0] rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  `QPD_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into a full job queue")
  `QPD_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from an empty job queue")

endmodule

@@ rtl/qpd_back.sv @@
`include "assert_macros.svh"

// Signal and noise level tracking. For a test job the weighted level difference is
// formed as the job is popped, and the threshold is compared in the test state.
module qpd_back import qpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  job_t               job_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IDX_W-1:0]   peak_index_o,
  output logic [SUM_W-1:0]   peak_height_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TEST = 2'b10
  } back_state_e;

  back_state_e         state_q;
  logic [LEVEL_W-1:0]  signal_q;
  logic [LEVEL_W-1:0]  noise_q;
  logic [IDX_W-1:0]    last_peak_q;
  logic                have_peak_q;

  logic [IDX_W-1:0]         cand_q;
  logic [SUM_W-1:0]         cur_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     gap_q;

  logic                     out_valid_q;
  logic                     out_valid_d;
  logic [IDX_W-1:0]         peak_index_q;
  logic [SUM_W-1:0]         peak_height_q;

  // On pop: factor times level difference, refractory gap.
  logic signed [LEVEL_W:0]    lvl_diff;
  logic signed [FACTOR_W:0]   fac_s;
  logic signed [PROD_W-1:0]   prod;
  logic [IDX_W-1:0]           idx_gap;
  logic                       gap;

  assign lvl_diff = $signed({1'b0, signal_q}) - $signed({1'b0, noise_q});
  assign fac_s    = $signed({1'b0, cfg_i.thr_weight});
  assign prod     = lvl_diff * fac_s;
  assign idx_gap  = job_i.index - last_peak_q;
  assign gap      = !have_peak_q || (idx_gap >= IDX_W'(cfg_i.refractory_len));

  assign pop_o = (state_q == ST_IDLE) && !q_empty_i;

  // Test state: threshold comparison.
  logic signed [CMP_W-1:0] rhs;
  logic signed [CMP_W-1:0] lhs;
  logic                    in_test;
  logic                    out_free;
  logic                    done;
  logic                    is_qrs;

  assign rhs      = CMP_W'(prod_q) + CMP_W'({noise_q, THR_SHIFT'(0)});
  assign lhs      = CMP_W'({cur_q, VAL_SHIFT'(0)});
  assign in_test  = (state_q == ST_TEST);
  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = in_test && out_free;
  assign is_qrs   = (lhs > rhs) && gap_q;

  // A waiting result is held while stalled; a new one may replace it in the
  // cycle that it is taken.
  assign out_valid_d = (done && is_qrs) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      signal_q    <= '0;
      noise_q     <= '0;
      last_peak_q <= '0;
      have_peak_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (job_i.kind == JOB_SEED) begin
              signal_q <= seed_level(job_i.value);
              noise_q  <= seed_level(job_i.value);
            end else begin
              state_q <= ST_TEST;
            end
          end
        end
        ST_TEST: begin
          if (done) begin
            state_q <= ST_IDLE;
            if (is_qrs) begin
              signal_q    <= step_level(signal_q, cur_q);
              last_peak_q <= cand_q;
              have_peak_q <= 1'b1;
            end else begin
              noise_q <= step_level(noise_q, cur_q);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cand_q <= job_i.index;
      cur_q  <= job_i.value;
      prod_q <= prod;
      gap_q  <= gap;
    end
    if (done && is_qrs) begin
      peak_index_q  <= cand_q;
      peak_height_q <= cur_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign peak_index_o  = peak_index_q;
  assign peak_height_o = peak_height_q;

  `QPD_ASSERT_NEXT(a_hold_test, clk_i, rst_ni, in_test && !out_free, in_test, "blocked test left")
  `QPD_ASSERT_IMPL(a_result_src, clk_i, rst_ni, $rose(out_valid_q), $past(in_test), "stray result")

endmodule
